[rtl/core/ecal_pkg.sv]
// ----------------------------------------------------------------------------
// ecal_pkg: shared constants and types for the epoch-to-calendar converter
// Field widths, calendar constants and the result structs passed from the
// date and time-of-day pipelines to the top level.
// ----------------------------------------------------------------------------
package ecal_pkg;

  // field widths
  localparam int unsigned SECS_W  = 31;
  localparam int unsigned DAYS_W  = 15;
  localparam int unsigned TOD_W   = 17;
  localparam int unsigned YEAR_W  = 11;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DOM_W   = 5;
  localparam int unsigned DOY_W   = 9;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;

  // 86400 = 675 * 2^7: day split is a shift plus a divide by 675
  localparam int unsigned DAY_SHIFT     = 7;
  localparam int unsigned DAY_DIV       = 675;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;

  // calendar constants
  localparam int unsigned DAYS_TO_1969_END = 25567;
  localparam int unsigned DAYS_TO_2000_END = 36890;
  localparam int unsigned DAYS_PER_4Y      = 1461;
  localparam int unsigned DAYS_PER_YEAR    = 365;
  localparam int unsigned MONTH_MUL        = 67;
  localparam int unsigned MONTH_ADD        = 2012;
  localparam int unsigned MONTH_SHIFT      = 11;   // divide by 2048
  localparam int unsigned DAY_MUL          = 489;
  localparam int unsigned BASE_1900        = 1900;
  localparam int unsigned BASE_2000        = 2000;

  // length of the valid chain from accepted start to the result strobe
  localparam int unsigned PIPE_DEPTH = 8;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DOM_W-1:0]   day_of_month;
    logic [DOY_W-1:0]   day_of_year;
  } date_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } tod_t;

endpackage

[rtl/core/ecal_cdiv.sv]
// ----------------------------------------------------------------------------
// ecal_cdiv: two-stage divide by a constant
// Stage 1 estimates the quotient with a reciprocal multiply (never high,
// at most one low); stage 2 forms the remainder and corrects by one.
// ----------------------------------------------------------------------------
module ecal_cdiv #(
  parameter int unsigned W  = 16,
  parameter int unsigned D  = 3,
  parameter int unsigned QW = $clog2(((2 ** W) - 1) / D + 1),
  parameter int unsigned RW = $clog2(D)
) (
  input  logic          clk_i,
  input  logic [W-1:0]  x_i,
  output logic [QW-1:0] q_o,
  output logic [RW-1:0] r_o
);

  localparam int unsigned M  = (2 ** W) / D;
  localparam int unsigned MW = $clog2(M + 1);

  logic [W+MW-1:0] prod;
  logic [MW-1:0]   est_d, est_q;
  logic [W-1:0]    x_q;
  logic [W-1:0]    back, diff;
  logic            fix;
  logic [QW-1:0]   q_d, q_q;
  logic [RW-1:0]   r_d, r_q;

  // stage 1: estimate
  assign prod  = (W + MW)'(x_i) * (W + MW)'(M);
  assign est_d = prod[W+MW-1:W];

  always_ff @(posedge clk_i) begin
    x_q   <= x_i;
    est_q <= est_d;
  end

  // stage 2: remainder and correction
  assign back = W'(est_q) * W'(D);
  assign diff = x_q - back;
  assign fix  = (diff >= W'(D));
  assign q_d  = QW'(est_q) + QW'(fix);
  assign r_d  = fix ? RW'(diff - W'(D)) : RW'(diff);

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
  end

  assign q_o = q_q;
  assign r_o = r_q;

endmodule

[rtl/core/ecal_tod.sv]
// ----------------------------------------------------------------------------
// ecal_tod: time-of-day pipeline
// Splits seconds within the day into hour, minute and second, delayed to
// line up with the date pipeline.
// ----------------------------------------------------------------------------
module ecal_tod (
  input  logic                       clk_i,
  input  logic [ecal_pkg::TOD_W-1:0] tod_i,
  output ecal_pkg::tod_t             tod_o
);

  localparam int unsigned HQW = $clog2(((2 ** ecal_pkg::TOD_W) - 1)
                                       / ecal_pkg::SECS_PER_HOUR + 1);
  localparam int unsigned HRW = $clog2(ecal_pkg::SECS_PER_HOUR);
  localparam int unsigned MQW = $clog2(((2 ** HRW) - 1) / ecal_pkg::SECS_PER_MIN + 1);
  localparam int unsigned MRW = $clog2(ecal_pkg::SECS_PER_MIN);

  logic [HQW-1:0]                hour_full;
  logic [HRW-1:0]                sec_in_hour;
  logic [MQW-1:0]                min_full;
  logic [MRW-1:0]                sec_in_min;
  logic [ecal_pkg::HOUR_W-1:0]   hour_q [2];
  ecal_pkg::tod_t                dly_d;
  ecal_pkg::tod_t                dly_q [2];

  ecal_cdiv #(.W(ecal_pkg::TOD_W), .D(ecal_pkg::SECS_PER_HOUR)) u_hour (
    .clk_i (clk_i),
    .x_i   (tod_i),
    .q_o   (hour_full),
    .r_o   (sec_in_hour)
  );

  ecal_cdiv #(.W(HRW), .D(ecal_pkg::SECS_PER_MIN)) u_min (
    .clk_i (clk_i),
    .x_i   (sec_in_hour),
    .q_o   (min_full),
    .r_o   (sec_in_min)
  );

  // hour rides along while minutes are split
  always_ff @(posedge clk_i) begin
    hour_q[0] <= hour_full[ecal_pkg::HOUR_W-1:0];
    hour_q[1] <= hour_q[0];
  end

  always_comb begin
    dly_d.hour   = hour_q[1];
    dly_d.minute = min_full[ecal_pkg::MIN_W-1:0];
    dly_d.second = ecal_pkg::SEC_W'(sec_in_min);
  end

  // align with the two month/day stages of the date path
  always_ff @(posedge clk_i) begin
    dly_q[0] <= dly_d;
    dly_q[1] <= dly_q[0];
  end

  assign tod_o = dly_q[1];

endmodule

[rtl/core/ecal_date.sv]
// ----------------------------------------------------------------------------
// ecal_date: day count to calendar date pipeline
// Day count -> 4-year cycle -> year within cycle -> year, day of year ->
// month and day of month by multiply-shift.
// ----------------------------------------------------------------------------
module ecal_date (
  input  logic                        clk_i,
  input  logic [ecal_pkg::DAYS_W-1:0] days_i,
  output ecal_pkg::date_t             date_o
);

  localparam int unsigned EW  = 16;   // 1-based day number since 1900
  localparam int unsigned CQW = $clog2(((2 ** EW) - 1) / ecal_pkg::DAYS_PER_4Y + 1);
  localparam int unsigned RW  = $clog2(ecal_pkg::DAYS_PER_4Y);
  localparam int unsigned PW  = RW + 2;
  localparam int unsigned PQW = $clog2(((2 ** PW) - 1) / ecal_pkg::DAYS_PER_4Y + 1);
  localparam int unsigned JW  = ecal_pkg::DOY_W;
  localparam int unsigned MPW = 15;   // month product width
  localparam int unsigned DPW = 13;   // day product width

  // stage A: era select and offset into the 4-year cycles
  logic [EW-1:0]  dnum, em1;
  logic           era;
  logic           era_q [4];
  logic [CQW-1:0] cyc;
  logic [RW-1:0]  r0;
  logic [RW-1:0]  rem;
  logic [PW-1:0]  px;
  logic [PQW-1:0] py_full;
  logic [CQW-1:0] cyc_q [2];
  logic [RW-1:0]  rem_q [2];

  assign dnum = EW'(days_i) + EW'(ecal_pkg::DAYS_TO_1969_END) + EW'(1);
  assign era  = (dnum > EW'(ecal_pkg::DAYS_TO_2000_END));
  assign em1  = era ? (dnum - EW'(ecal_pkg::DAYS_TO_2000_END) - EW'(1))
                    : (dnum - EW'(ecal_pkg::DAYS_PER_YEAR) - EW'(1));

  ecal_cdiv #(.W(EW), .D(ecal_pkg::DAYS_PER_4Y)) u_cyc (
    .clk_i (clk_i),
    .x_i   (em1),
    .q_o   (cyc),
    .r_o   (r0)
  );

  // position within the cycle, then year within the cycle
  assign rem = r0 + RW'(1);
  assign px  = (PW'(rem) << 2) - PW'(1);

  ecal_cdiv #(.W(PW), .D(ecal_pkg::DAYS_PER_4Y)) u_py (
    .clk_i (clk_i),
    .x_i   (px),
    .q_o   (py_full),
    .r_o   ()
  );

  always_ff @(posedge clk_i) begin
    era_q[0] <= era;
    era_q[1] <= era_q[0];
    era_q[2] <= era_q[1];
    era_q[3] <= era_q[2];
    cyc_q[0] <= cyc;
    cyc_q[1] <= cyc_q[0];
    rem_q[0] <= rem;
    rem_q[1] <= rem_q[0];
  end

  // stage B: year, day of year, month
  logic [1:0]                   py;
  logic [ecal_pkg::YEAR_W-1:0]  year_d, year_q, year_o_q;
  logic [ecal_pkg::YEAR_W-1:0]  base;
  logic [ecal_pkg::DOY_W-1:0]   doy_d, doy_q, doy_o_q;
  logic                         leap;
  logic [1:0]                   skip;
  logic [JW-1:0]                j_d, j_q;
  logic [MPW-1:0]               mprod;
  logic [ecal_pkg::MONTH_W-1:0] mon_d, mon_q, mon_o_q;

  assign py     = py_full[1:0];
  assign base   = era_q[3] ? ecal_pkg::YEAR_W'(ecal_pkg::BASE_2000 + 1)
                           : ecal_pkg::YEAR_W'(ecal_pkg::BASE_1900 + 1);
  assign year_d = base + ecal_pkg::YEAR_W'({cyc_q[1], 2'b00}) + ecal_pkg::YEAR_W'(py);
  assign doy_d  = ecal_pkg::DOY_W'(rem_q[1])
                - ecal_pkg::DOY_W'(py) * ecal_pkg::DOY_W'(ecal_pkg::DAYS_PER_YEAR);

  // only years 1970..2038 occur, so divisibility by 4 decides
  assign leap = (year_d[1:0] == 2'b00);
  assign skip = leap ? 2'd1 : 2'd2;
  assign j_d  = (doy_d > (JW'(61) - JW'(skip))) ? (doy_d + JW'(skip)) : doy_d;

  assign mprod = MPW'(j_d) * MPW'(ecal_pkg::MONTH_MUL) + MPW'(ecal_pkg::MONTH_ADD);
  assign mon_d = mprod[ecal_pkg::MONTH_SHIFT +: ecal_pkg::MONTH_W];

  always_ff @(posedge clk_i) begin
    year_q <= year_d;
    doy_q  <= doy_d;
    j_q    <= j_d;
    mon_q  <= mon_d;
  end

  // stage C: day of month
  logic [DPW-1:0]              dprod;
  logic [JW:0]                 dom_full;
  logic [ecal_pkg::DOM_W-1:0]  dom_d, dom_o_q;

  assign dprod    = DPW'(mon_q) * DPW'(ecal_pkg::DAY_MUL);
  assign dom_full = (JW + 1)'(j_q) + (JW + 1)'(30) - (JW + 1)'(dprod[DPW-1:4]);
  assign dom_d    = dom_full[ecal_pkg::DOM_W-1:0];

  always_ff @(posedge clk_i) begin
    year_o_q <= year_q;
    doy_o_q  <= doy_q;
    mon_o_q  <= mon_q;
    dom_o_q  <= dom_d;
  end

  always_comb begin
    date_o.year         = year_o_q;
    date_o.month        = mon_o_q;
    date_o.day_of_month = dom_o_q;
    date_o.day_of_year  = doy_o_q;
  end

endmodule

[rtl/core/epoch_seconds_to_calendar.sv]
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: seconds since 1970-01-01 to calendar fields
// Fully pipelined converter from a 31-bit epoch second count to year, month,
// day of month, day of year, hour, minute and second.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive epoch_seconds_i and raise start_i; a transaction is taken at
//   every rising edge with start_i high and busy_o low. busy_o is always low,
//   so a new transaction can be issued every cycle.
//   Output: each result appears on the result ports for exactly one cycle
//   with done_o high. The receiver has no backpressure and must take it.
//   Pipeline: reciprocal-multiply dividers (day split, hour split, minute
//   split, 4-year cycle, year in cycle) followed by two month/day stages.
//   Throughput: one transaction per cycle, set by that pipeline.
//   Results leave in issue order.
//   Reset: rst_ni (async, active low) clears the valid chain, so no done_o
//   strobes follow reset until new transactions are issued. Datapath
//   registers are not reset.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [ecal_pkg::SECS_W-1:0]  epoch_seconds_i,
  output logic                         done_o,
  output logic [ecal_pkg::YEAR_W-1:0]  year_o,
  output logic [ecal_pkg::MONTH_W-1:0] month_o,
  output logic [ecal_pkg::DOM_W-1:0]   day_of_month_o,
  output logic [ecal_pkg::DOY_W-1:0]   day_of_year_o,
  output logic [ecal_pkg::HOUR_W-1:0]  hour_o,
  output logic [ecal_pkg::MIN_W-1:0]   minute_o,
  output logic [ecal_pkg::SEC_W-1:0]   second_o
);

  localparam int unsigned XW  = ecal_pkg::SECS_W - ecal_pkg::DAY_SHIFT;
  localparam int unsigned DRW = $clog2(ecal_pkg::DAY_DIV);
  localparam int unsigned DEP = ecal_pkg::PIPE_DEPTH;

  // Valid chain: one bit per pipeline stage, cleared at reset.
  logic           accept;
  logic [DEP-1:0] vld_d, vld_q;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;
  assign vld_d  = {vld_q[DEP-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Day split: seconds / 86400 is (seconds >> 7) / 675; the low seven bits
  // rejoin the remainder to form the second of the day.
  logic [ecal_pkg::DAYS_W-1:0]    days;
  logic [DRW-1:0]                 rem675;
  logic [ecal_pkg::DAY_SHIFT-1:0] lo_q [2];
  logic [ecal_pkg::TOD_W-1:0]     tod;

  ecal_cdiv #(.W(XW), .D(ecal_pkg::DAY_DIV)) u_days (
    .clk_i (clk_i),
    .x_i   (epoch_seconds_i[ecal_pkg::SECS_W-1:ecal_pkg::DAY_SHIFT]),
    .q_o   (days),
    .r_o   (rem675)
  );

  always_ff @(posedge clk_i) begin
    lo_q[0] <= epoch_seconds_i[ecal_pkg::DAY_SHIFT-1:0];
    lo_q[1] <= lo_q[0];
  end

  assign tod = {rem675, lo_q[1]};

  // Date and time-of-day pipelines run side by side with equal latency.
  ecal_pkg::date_t date;
  ecal_pkg::tod_t  tday;

  ecal_date u_date (
    .clk_i  (clk_i),
    .days_i (days),
    .date_o (date)
  );

  ecal_tod u_tod (
    .clk_i (clk_i),
    .tod_i (tod),
    .tod_o (tday)
  );

  assign done_o         = vld_q[DEP-1];
  assign year_o         = date.year;
  assign month_o        = date.month;
  assign day_of_month_o = date.day_of_month;
  assign day_of_year_o  = date.day_of_year;
  assign hour_o         = tday.hour;
  assign minute_o       = tday.minute;
  assign second_o       = tday.second;

  // Every strobe traces back to an earlier accepted transaction.
  a_done_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, DEP))
    else $error("done_o without matching start");

  a_month_dom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (month_o >= 4'd1 && month_o <= 4'd12 &&
                day_of_month_o >= 5'd1))
    else $error("month or day of month out of range");

  a_doy_leap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (day_of_year_o >= 9'd1 && day_of_year_o <= 9'd366 &&
                (day_of_year_o != 9'd366 || year_o[1:0] == 2'b00)))
    else $error("day of year out of range for year");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hour_o < 5'd24 && minute_o < 6'd60 && second_o < 6'd60))
    else $error("time of day out of range");

endmodule

[dv/epoch_seconds_to_calendar_test.sv]
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_test: self-checking bench for the epoch converter
// Sends epoch second counts through the start/busy handshake and predicts
// each calendar result with an in-bench Gregorian model. Every done_o strobe
// is checked field by field, in order, against the oldest open prediction.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_test;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles the bench may run before it gives up
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_ITEMS  = 1200;
  // last stretch of the random part runs back to back, no idle cycles
  localparam int unsigned IDLE_FREE_TAIL = 200;
  localparam int unsigned MAX_EPOCH     = 32'h7FFF_FFFF;
  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned LAST_DAY      = 24855;  // day count of 2038-01-19
  // Gregorian cycle lengths used after 2000
  localparam int unsigned DAYS_PER_100Y = 36524;
  localparam int unsigned DAYS_PER_400Y = 146097;

  // one predicted transaction: the input it came from plus calendar fields
  typedef struct {
    logic [ecal_pkg::SECS_W-1:0] epoch;
    ecal_pkg::date_t             date;
    ecal_pkg::tod_t              tod;
  } calendar_entry_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts on accepted inputs, checks on result strobes.
  // --------------------------------------------------------------------------
  class calendar_board;
    calendar_entry_t pending_dates[$];
    int unsigned     failures;
    int unsigned     reported;

    function bit is_leap_year(int unsigned y);
      if ((y % 4) != 0) return 1'b0;
      if (y == 1800 || y == 1900) return 1'b0;
      if (y < 2100) return 1'b1;
      if ((y % 400) == 0) return 1'b1;
      return (y % 100) != 0;
    endfunction

    // 1-based day count split into 4-year cycles -> year offset and day of year
    function void split_quad(input int unsigned d, output int unsigned yoff,
                             output int unsigned doy);
      int unsigned cyc, rem, py;
      cyc  = (d - 1) / ecal_pkg::DAYS_PER_4Y;
      rem  = d - ecal_pkg::DAYS_PER_4Y * cyc;
      py   = (4 * rem - 1) / ecal_pkg::DAYS_PER_4Y;
      doy  = rem - ecal_pkg::DAYS_PER_YEAR * py;
      yoff = 4 * cyc + py;
    endfunction

    function calendar_entry_t calendar_from_seconds(
      logic [ecal_pkg::SECS_W-1:0] epoch
    );
      int unsigned secs, mins, hours, days, d, yoff, doy, year;
      int unsigned p400, p100, skip, j, mon, dom;
      calendar_entry_t e;
      secs  = epoch;
      mins  = secs / 60;
      secs  = secs - 60 * mins;
      hours = mins / 60;
      mins  = mins - 60 * hours;
      days  = hours / 24;
      hours = hours - 24 * days;

      // day count since 1900, 1-based
      d = days + 1 + ecal_pkg::DAYS_TO_1969_END;
      if (d <= ecal_pkg::DAYS_TO_2000_END) begin
        split_quad(d - ecal_pkg::DAYS_PER_YEAR, yoff, doy);
        year = ecal_pkg::BASE_1900 + yoff + 1;
      end else begin
        d    = d - ecal_pkg::DAYS_TO_2000_END;
        p400 = (d - 1) / DAYS_PER_400Y;
        d    = d - DAYS_PER_400Y * p400;
        if (d < DAYS_PER_400Y) begin
          p100 = (d - 1) / DAYS_PER_100Y;
          d    = d - DAYS_PER_100Y * p100;
          split_quad(d, yoff, doy);
          year = ecal_pkg::BASE_2000 + 400 * p400 + 100 * p100 + yoff + 1;
        end else begin
          // last day of a 400-year cycle
          doy  = 366;
          year = ecal_pkg::BASE_2000 + 400 * (p400 + 1);
        end
      end

      // shift day of year past the days February lacks, then multiply-shift
      skip = is_leap_year(year) ? 1 : 2;
      j    = doy;
      if (j > 61 - skip) j = j + skip;
      mon = (j * ecal_pkg::MONTH_MUL + ecal_pkg::MONTH_ADD) >> ecal_pkg::MONTH_SHIFT;
      dom = j + 30 - (mon * ecal_pkg::DAY_MUL) / 16;

      e.epoch             = epoch;
      e.date.year         = ecal_pkg::YEAR_W'(year);
      e.date.month        = ecal_pkg::MONTH_W'(mon);
      e.date.day_of_month = ecal_pkg::DOM_W'(dom);
      e.date.day_of_year  = ecal_pkg::DOY_W'(doy);
      e.tod.hour          = ecal_pkg::HOUR_W'(hours);
      e.tod.minute        = ecal_pkg::MIN_W'(mins);
      e.tod.second        = ecal_pkg::SEC_W'(secs);
      return e;
    endfunction

    function void note_request(logic [ecal_pkg::SECS_W-1:0] epoch);
      pending_dates.push_back(calendar_from_seconds(epoch));
    endfunction

    function void check_result(ecal_pkg::date_t got_date, ecal_pkg::tod_t got_tod);
      calendar_entry_t want;
      if (pending_dates.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("unexpected result: %0d-%0d-%0d doy %0d %0d:%0d:%0d",
                   got_date.year, got_date.month, got_date.day_of_month,
                   got_date.day_of_year, got_tod.hour, got_tod.minute,
                   got_tod.second);
        end
        return;
      end
      want = pending_dates.pop_front();
      if (got_date.year         !== want.date.year         ||
          got_date.month        !== want.date.month        ||
          got_date.day_of_month !== want.date.day_of_month ||
          got_date.day_of_year  !== want.date.day_of_year  ||
          got_tod.hour          !== want.tod.hour          ||
          got_tod.minute        !== want.tod.minute        ||
          got_tod.second        !== want.tod.second) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("mismatch for epoch %0d: expected %0d-%0d-%0d doy %0d %0d:%0d:%0d",
                   want.epoch, want.date.year, want.date.month,
                   want.date.day_of_month, want.date.day_of_year,
                   want.tod.hour, want.tod.minute, want.tod.second);
          $display("  actual %0d-%0d-%0d doy %0d %0d:%0d:%0d",
                   got_date.year, got_date.month, got_date.day_of_month,
                   got_date.day_of_year, got_tod.hour, got_tod.minute,
                   got_tod.second);
        end
      end
    endfunction

    function int unsigned pending();
      return pending_dates.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic                        clk_i   = 1'b0;
  logic                        rst_ni  = 1'b0;
  logic                        start_i = 1'b0;
  logic [ecal_pkg::SECS_W-1:0] epoch_seconds_i = '0;
  logic                        busy_o;
  logic                        done_o;
  ecal_pkg::date_t             got_date;
  ecal_pkg::tod_t              got_tod;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  epoch_seconds_to_calendar dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .epoch_seconds_i(epoch_seconds_i),
    .done_o         (done_o),
    .year_o         (got_date.year),
    .month_o        (got_date.month),
    .day_of_month_o (got_date.day_of_month),
    .day_of_year_o  (got_date.day_of_year),
    .hour_o         (got_tod.hour),
    .minute_o       (got_tod.minute),
    .second_o       (got_tod.second)
  );

  calendar_board board = new();

  // --------------------------------------------------------------------------
  // Monitor: samples at the rising edge, before the bench's own NBA updates,
  // so it sees exactly what the DUT sees at that edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) board.note_request(epoch_seconds_i);
      if (done_o) board.check_result(got_date, got_tod);
    end
  end

  // watchdog; a hang anywhere ends the run as a failure
  int unsigned cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver. Called at a rising edge; returns at the edge that took the
  // transaction. start_i stays high across back-to-back transactions and is
  // only dropped for an idle burst.
  // --------------------------------------------------------------------------
  task automatic send_epoch(input logic [ecal_pkg::SECS_W-1:0] secs,
                            input bit allow_idle);
    int unsigned gap;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i         <= 1'b1;
    epoch_seconds_i <= secs;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Random epoch: full range, day edges, or the Feb/Mar and year-end days
  // where the leap-year handling matters.
  function automatic logic [ecal_pkg::SECS_W-1:0] random_epoch();
    longint unsigned v;
    int unsigned     day, y, sod;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, MAX_EPOCH);
      1: begin
        day = $urandom_range(0, LAST_DAY);
        case ($urandom_range(0, 2))
          0:       sod = 0;
          1:       sod = SECS_PER_DAY - 1;
          default: sod = $urandom_range(0, SECS_PER_DAY - 1);
        endcase
        v = longint'(day) * SECS_PER_DAY + sod;
      end
      default: begin
        y = $urandom_range(1970, 2037);
        // leap days in 1970..y-1 (no century exception in this span)
        day = (y - 1970) * ecal_pkg::DAYS_PER_YEAR + (y - 1969) / 4;
        if ($urandom_range(0, 1) == 0) day = day + $urandom_range(55, 61);
        else day = day + $urandom_range(363, 365);
        v = longint'(day) * SECS_PER_DAY + $urandom_range(0, SECS_PER_DAY - 1);
      end
    endcase
    if (v > MAX_EPOCH) v = MAX_EPOCH;
    return ecal_pkg::SECS_W'(v);
  endfunction

  // directed values: field extremes, leap days, century and year edges
  logic [ecal_pkg::SECS_W-1:0] directed_epochs[] = '{
    31'd0,          31'd59,         31'd60,         31'd3599,
    31'd3600,       31'd86399,      31'd86400,
    31'd5011200,    // 1970-02-28, non-leap February
    31'd5097600,    // 1970-03-01
    31'd68169600,   // 1972-02-29
    31'd68256000,   // 1972-03-01
    31'd94694399,   // 1972-12-31 23:59:59, day 366
    31'd946684799,  // 1999-12-31 23:59:59
    31'd951782400,  // 2000-02-29, century leap year
    31'd978307199,  // last second of the 4-year-cycle range
    31'd978307200,  // first second of the Gregorian-cycle range
    31'd2145916799, // 2037-12-31 23:59:59
    31'd2147483647, // latest representable time
    31'd1073741824, 31'h5555_5555, 31'h2AAA_AAAA
  };

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    bit allow_idle;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_epochs[i]) send_epoch(directed_epochs[i], i % 3 == 1);

    // random part: idle in most blocks of 100, none in some, none at the end
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      allow_idle = (n < RANDOM_ITEMS - IDLE_FREE_TAIL) && ((n / 100) % 3 != 2);
      send_epoch(random_epoch(), allow_idle);
    end
    start_i <= 1'b0;

    // drain the pipeline, then give stray strobes a chance to show up
    while (board.pending() != 0) @(posedge clk_i);
    repeat (ecal_pkg::PIPE_DEPTH + 4) @(posedge clk_i);

    if (board.failures == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/ecal_pkg.sv
rtl/core/ecal_cdiv.sv
rtl/core/ecal_tod.sv
rtl/core/ecal_date.sv
rtl/core/epoch_seconds_to_calendar.sv
dv/epoch_seconds_to_calendar_test.sv
